>>> hdl/usv_pkg.sv
// ============================================================================
// usv_pkg: shared types and constants for the UV sphere vertex generator
// Reset values, register indexes, vertex order tables and sideband structs.
// ============================================================================
`default_nettype none

package usv_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF        = 15;

    localparam int COUNT_W  = 8;
    localparam int TEX_W    = 17;
    localparam int CORNER_W = 3;
    localparam int OUT_W    = 16;

    localparam logic [COUNT_W-1:0]  SEGMENT_COUNT_RESET = 8'd32;
    localparam logic [COUNT_W-1:0]  RING_COUNT_RESET    = 8'd16;
    localparam logic [CORNER_W-1:0] LAST_CORNER         = 3'd5;

    // Twice the Q1.16 one, for texture numerators (2 * 65536)
    localparam int TEX_SCALE2 = 131072;

    typedef enum logic {
        REG_SEGMENT_COUNT = 1'b0,
        REG_RING_COUNT    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CORNER_W-1:0] corner;
        logic                last_vertex;
    } tag_t;

    typedef struct packed {
        logic [CORNER_W-1:0] corner;
        logic                last_vertex;
        logic [TEX_W-1:0]    tex_u;
        logic [TEX_W-1:0]    tex_v;
    } vtx_side_t;

    // ring step of each corner: (r,s) (r+1,s) (r,s+1) (r,s+1) (r+1,s) (r+1,s+1)
    function automatic logic corner_dr(input logic [CORNER_W-1:0] c);
        logic d;
        case (c)
            3'd1, 3'd4, 3'd5: d = 1'b1;
            default:          d = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic corner_ds(input logic [CORNER_W-1:0] c);
        logic d;
        case (c)
            3'd2, 3'd3, 3'd5: d = 1'b1;
            default:          d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hdl/usv_div_pipe.sv
// ============================================================================
// usv_div_pipe: pipelined restoring divider
// One quotient bit per stage; floor(num / den), quotient must fit QUO_W bits.
// ============================================================================
`default_nettype none

module usv_div_pipe #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 9,
    parameter int QUO_W = 17
) (
    input  wire logic             clk,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int WW = NUM_W + DEN_W;

    logic [NUM_W-1:0] rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];

    logic [NUM_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    always_comb
    begin
        logic [WW-1:0] trial;
        logic [WW-1:0] rem_w;
        for (int j = 0; j < QUO_W; j++)
        begin
            trial = WW'(den_reg[j]) << (QUO_W - 1 - j);
            rem_w = WW'(rem_reg[j]);
            if (rem_w >= trial)
            begin
                rem_next[j] = NUM_W'(rem_w - trial);
                quo_next[j] = quo_reg[j] | (QUO_W'(1) << (QUO_W - 1 - j));
            end
            else
            begin
                rem_next[j] = rem_reg[j];
                quo_next[j] = quo_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        for (int j = 0; j < QUO_W; j++)
        begin
            rem_reg[j+1] <= rem_next[j];
            den_reg[j+1] <= den_reg[j];
            quo_reg[j+1] <= quo_next[j];
        end
    end

    assign quo = quo_reg[QUO_W];

endmodule

`default_nettype wire

>>> hdl/usv_sine_rom.sv
// ============================================================================
// usv_sine_rom: two-port sine/cosine table
// Word k holds {sin, cos} of 2*pi*k/depth; registered read on both ports.
// ============================================================================
`default_nettype none

module usv_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRAC_BITS        = 15
) (
    input  wire logic                                clk,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_a,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_b,
    output logic      [2*(FRAC_BITS+2)-1:0]          data_a,
    output logic      [2*(FRAC_BITS+2)-1:0]          data_b
);

    localparam int          TW          = FRAC_BITS + 2;
    localparam longint      HALF_PI_Q30 = 64'd1686629713;
    localparam longint      ONE_Q30     = 64'd1 << 30;

    typedef logic [2*TW-1:0] rom_word_t;
    typedef rom_word_t rom_arr_t [SINE_TABLE_DEPTH];

    function automatic logic signed [63:0] taylor_q30(input logic [63:0] x,
                                                      input logic want_sin);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = want_sin ? x : ONE_Q30;
        sum  = $signed(term);
        for (int n = 1; n <= 8; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1: term = want_sin ? term / 64'd6   : term / 64'd2;
                2: term = want_sin ? term / 64'd20  : term / 64'd12;
                3: term = want_sin ? term / 64'd42  : term / 64'd30;
                4: term = want_sin ? term / 64'd72  : term / 64'd56;
                5: term = want_sin ? term / 64'd110 : term / 64'd90;
                6: term = want_sin ? term / 64'd156 : term / 64'd132;
                7: term = want_sin ? term / 64'd210 : term / 64'd182;
                default: term = want_sin ? term / 64'd272 : term / 64'd240;
            endcase
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] q30_round(input logic signed [63:0] v);
        logic        neg;
        logic [63:0] mag;
        neg = v < 0;
        mag = neg ? 64'(-v) : 64'(v);
        if (FRAC_BITS < 30)
            mag = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic rom_word_t rom_entry(input int k);
        logic [63:0]        a;
        logic [63:0]        q;
        logic [63:0]        m;
        logic [63:0]        x;
        logic signed [63:0] s0;
        logic signed [63:0] c0;
        logic signed [63:0] sv;
        logic signed [63:0] cv;
        logic signed [63:0] sr;
        logic signed [63:0] cr;
        a  = 64'(4 * k);
        q  = a / SINE_TABLE_DEPTH;
        m  = a % SINE_TABLE_DEPTH;
        x  = (HALF_PI_Q30 * m + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
        s0 = taylor_q30(x, 1'b1);
        c0 = taylor_q30(x, 1'b0);
        case (q[1:0])
            2'd0:    begin sv = s0;  cv = c0;  end
            2'd1:    begin sv = c0;  cv = -s0; end
            2'd2:    begin sv = -s0; cv = -c0; end
            default: begin sv = -c0; cv = s0;  end
        endcase
        sr = q30_round(sv);
        cr = q30_round(cv);
        return {sr[TW-1:0], cr[TW-1:0]};
    endfunction

    function automatic rom_arr_t build_table();
        rom_arr_t t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            t[k] = rom_entry(k);
        return t;
    endfunction

    localparam rom_arr_t ROM_TABLE = build_table();

    always_ff @(posedge clk)
    begin
        data_a <= ROM_TABLE[addr_a];
        data_b <= ROM_TABLE[addr_b];
    end

endmodule

`default_nettype wire

>>> hdl/usv_shade_stage.sv
// ============================================================================
// usv_shade_stage: normal and position output stages
// Stage 1 forms the two sine products; stage 2 rounds and saturates to Q1.15.
// ============================================================================
`default_nettype none

module usv_shade_stage
    import usv_pkg::*;
#(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire vtx_side_t                   in_side,
    input  wire logic signed [FRAC_BITS+1:0] sin_t,
    input  wire logic signed [FRAC_BITS+1:0] cos_t,
    input  wire logic signed [FRAC_BITS+1:0] sin_p,
    input  wire logic signed [FRAC_BITS+1:0] cos_p,
    output logic                             done,
    output logic signed [OUT_W-1:0]          pos_x,
    output logic signed [OUT_W-1:0]          pos_y,
    output logic signed [OUT_W-1:0]          pos_z,
    output logic signed [OUT_W-1:0]          norm_x,
    output logic signed [OUT_W-1:0]          norm_y,
    output logic signed [OUT_W-1:0]          norm_z,
    output logic [TEX_W-1:0]                 tex_u,
    output logic [TEX_W-1:0]                 tex_v,
    output logic [CORNER_W-1:0]              corner,
    output logic                             last_vertex
);

    localparam int TW = FRAC_BITS + 2;
    localparam int PW = 2 * TW;
    localparam int MW = PW + 16;

    function automatic logic [OUT_W-1:0] to_q15(input logic signed [PW-1:0] v,
                                                input int fb);
        logic          neg;
        logic [MW-1:0] sext;
        logic [MW-1:0] mag;
        neg  = v[PW-1];
        sext = {{16{v[PW-1]}}, v};
        mag  = neg ? (~sext + MW'(1)) : sext;
        if (fb > 15)
            mag = (mag + (MW'(1) << (fb - 16))) >> (fb - 15);
        else
            mag = mag << (15 - fb);
        if (!neg && mag > MW'(32767))
            mag = MW'(32767);
        if (neg && mag > MW'(32768))
            mag = MW'(32768);
        return neg ? OUT_W'(~mag[OUT_W-1:0] + 16'd1) : mag[OUT_W-1:0];
    endfunction

    logic                 mul_valid_reg;
    vtx_side_t            mul_side_reg;
    logic signed [PW-1:0] nx_reg;
    logic signed [PW-1:0] nz_reg;
    logic signed [PW-1:0] ct_reg;
    logic signed [PW-1:0] ct_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            done          <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            done          <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_side_reg <= in_side;
        nx_reg       <= cos_p * sin_t;
        nz_reg       <= sin_p * sin_t;
        ct_reg       <= PW'(cos_t);
    end

    assign ct_ext = ct_reg;

    always_ff @(posedge clk)
    begin
        pos_x       <= to_q15(nx_reg, 2 * FRAC_BITS + 1);
        pos_y       <= to_q15(ct_ext, FRAC_BITS + 1);
        pos_z       <= to_q15(nz_reg, 2 * FRAC_BITS + 1);
        norm_x      <= to_q15(nx_reg, 2 * FRAC_BITS);
        norm_y      <= to_q15(ct_ext, FRAC_BITS);
        norm_z      <= to_q15(nz_reg, 2 * FRAC_BITS);
        tex_u       <= mul_side_reg.tex_u;
        tex_v       <= mul_side_reg.tex_v;
        corner      <= mul_side_reg.corner;
        last_vertex <= mul_side_reg.last_vertex;
    end

endmodule

`default_nettype wire

>>> hdl/uv_sphere_vertex_generator_top.sv
// ============================================================================
// uv_sphere_vertex_generator_top: UV sphere quad to triangle vertex pipeline
// Sequencer, angle/texture dividers, sine table and output stages.
// ============================================================================
// A quad is taken when start is high and busy is low; busy then stays high
// while the sequencer issues the quad's six vertices, one per cycle, and is
// low as the last one issues, so the next quad can be taken alongside it.
// A quad outside the configured ring or segment count is taken and produces
// nothing. Each vertex word appears with done high for one cycle, after it
// has passed the four pipelined angle and texture dividers, the sine table
// read, the product stage and the rounding stage. Vertices leave in order,
// back to back, and cannot be held off.
`default_nettype none

module uv_sphere_vertex_generator_top
    import usv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [COUNT_W-1:0]         cfg_data,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [COUNT_W-1:0]         ring_index,
    input  wire logic [COUNT_W-1:0]         segment_index,
    output logic                            done,
    output logic signed [OUT_W-1:0]         pos_x,
    output logic signed [OUT_W-1:0]         pos_y,
    output logic signed [OUT_W-1:0]         pos_z,
    output logic signed [OUT_W-1:0]         norm_x,
    output logic signed [OUT_W-1:0]         norm_y,
    output logic signed [OUT_W-1:0]         norm_z,
    output logic [TEX_W-1:0]                tex_u,
    output logic [TEX_W-1:0]                tex_v,
    output logic [CORNER_W-1:0]             corner,
    output logic                            last_vertex
);

    localparam int AW    = $clog2(SINE_TABLE_DEPTH);
    localparam int TW    = FRAC_BITS + 2;
    localparam int QUO_W = (AW + 2 > TEX_W) ? AW + 2 : TEX_W;
    localparam int DEN_W = COUNT_W + 1;
    localparam int NUM_W = QUO_W + DEN_W;
    localparam int L_DIV = QUO_W + 1;

    // configuration
    logic [COUNT_W-1:0] segment_count_reg;
    logic [COUNT_W-1:0] ring_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= SEGMENT_COUNT_RESET;
            ring_count_reg    <= RING_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SEGMENT_COUNT: segment_count_reg <= cfg_data;
                REG_RING_COUNT:    ring_count_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // vertex sequencer
    logic                active_reg;
    logic [CORNER_W-1:0] cnt_reg;
    logic [COUNT_W-1:0]  ri_reg;
    logic [COUNT_W-1:0]  si_reg;
    logic                accept;
    logic                in_range;

    assign busy     = active_reg && (cnt_reg != LAST_CORNER);
    assign accept   = start && !busy;
    assign in_range = (ring_index < ring_count_reg) && (segment_index < segment_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (accept && in_range)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            active_reg <= (cnt_reg != LAST_CORNER);
            cnt_reg    <= cnt_reg + CORNER_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ri_reg <= ring_index;
            si_reg <= segment_index;
        end
    end

    logic [DEN_W-1:0] vr;
    logic [DEN_W-1:0] vs;
    logic [DEN_W-1:0] den_r;
    logic [DEN_W-1:0] den_s;
    logic [NUM_W-1:0] num_ti;
    logic [NUM_W-1:0] num_pi;
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    tag_t             issue_tag;

    assign vr     = DEN_W'(ri_reg) + DEN_W'(corner_dr(cnt_reg));
    assign vs     = DEN_W'(si_reg) + DEN_W'(corner_ds(cnt_reg));
    assign den_r  = {ring_count_reg, 1'b0};
    assign den_s  = {segment_count_reg, 1'b0};
    assign num_ti = NUM_W'(vr) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(ring_count_reg);
    assign num_pi = NUM_W'(vs) * NUM_W'(2 * SINE_TABLE_DEPTH) + NUM_W'(segment_count_reg);
    assign num_u  = NUM_W'(vs) * NUM_W'(TEX_SCALE2) + NUM_W'(segment_count_reg);
    assign num_v  = NUM_W'(vr) * NUM_W'(TEX_SCALE2) + NUM_W'(ring_count_reg);

    assign issue_tag.corner      = cnt_reg;
    assign issue_tag.last_vertex = (cnt_reg == LAST_CORNER);

    // dividers
    logic [QUO_W-1:0] q_ti;
    logic [QUO_W-1:0] q_pi;
    logic [QUO_W-1:0] q_u;
    logic [QUO_W-1:0] q_v;

    usv_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_ti (
        .clk (clk), .num (num_ti), .den (den_r), .quo (q_ti)
    );

    usv_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_pi (
        .clk (clk), .num (num_pi), .den (den_s), .quo (q_pi)
    );

    usv_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_u (
        .clk (clk), .num (num_u), .den (den_s), .quo (q_u)
    );

    usv_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_v (
        .clk (clk), .num (num_v), .den (den_r), .quo (q_v)
    );

    logic [L_DIV-1:0] dly_valid_reg;
    tag_t             dly_tag_reg [L_DIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dly_valid_reg <= '0;
        else
            dly_valid_reg <= {dly_valid_reg[L_DIV-2:0], active_reg};
    end

    always_ff @(posedge clk)
    begin
        dly_tag_reg[0] <= issue_tag;
        for (int i = 1; i < L_DIV; i++)
            dly_tag_reg[i] <= dly_tag_reg[i-1];
    end

    // sine table
    logic [AW-1:0]     addr_t;
    logic [AW-1:0]     addr_p;
    logic [2*TW-1:0]   rom_t;
    logic [2*TW-1:0]   rom_p;
    logic              rom_valid_reg;
    vtx_side_t         rom_side_reg;

    assign addr_t = q_ti[AW-1:0];
    assign addr_p = (q_pi == QUO_W'(SINE_TABLE_DEPTH)) ? '0 : q_pi[AW-1:0];

    usv_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_rom (
        .clk    (clk),
        .addr_a (addr_t),
        .addr_b (addr_p),
        .data_a (rom_t),
        .data_b (rom_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rom_valid_reg <= 1'b0;
        else
            rom_valid_reg <= dly_valid_reg[L_DIV-1];
    end

    always_ff @(posedge clk)
    begin
        rom_side_reg.corner      <= dly_tag_reg[L_DIV-1].corner;
        rom_side_reg.last_vertex <= dly_tag_reg[L_DIV-1].last_vertex;
        rom_side_reg.tex_u       <= q_u[TEX_W-1:0];
        rom_side_reg.tex_v       <= q_v[TEX_W-1:0];
    end

    usv_shade_stage #(.FRAC_BITS(FRAC_BITS)) u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rom_valid_reg),
        .in_side     (rom_side_reg),
        .sin_t       (rom_t[2*TW-1:TW]),
        .cos_t       (rom_t[TW-1:0]),
        .sin_p       (rom_p[2*TW-1:TW]),
        .cos_p       (rom_p[TW-1:0]),
        .done        (done),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .corner      (corner),
        .last_vertex (last_vertex)
    );

    // corners leave in order, one per cycle
    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && (corner != '0) |-> $past(done) && ($past(corner) == corner - CORNER_W'(1)))
        else $error("vertex corner out of sequence");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_vertex |-> corner == LAST_CORNER)
        else $error("last_vertex not on final corner");

    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_range |=> active_reg && (cnt_reg == '0))
        else $error("sequencer did not start quad");

    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> active_reg && (cnt_reg == $past(cnt_reg) + CORNER_W'(1)))
        else $error("sequencer stalled mid-quad");

endmodule

`default_nettype wire

>>> tb/sv/uv_sphere_vertex_generator_top_tb.sv
// ============================================================================
// uv_sphere_vertex_generator_top_tb: self-checking bench for the vertex pipe
// Drives quads under several ring/segment settings, predicts the six vertex
// words of each in-range quad and compares every done word in order.
// ============================================================================
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_top_tb;
    import usv_pkg::*;

    localparam longint unsigned DEPTH   = SINE_TABLE_DEPTH_DEF;
    localparam int              FB      = FRAC_BITS_DEF;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam int              DRAIN   = 40;
    localparam int              WD_MAX  = 4000;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] pos_z;
        logic signed [OUT_W-1:0] norm_x;
        logic signed [OUT_W-1:0] norm_y;
        logic signed [OUT_W-1:0] norm_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic [CORNER_W-1:0]     corner;
        logic                    last_vertex;
    } vertex_t;

    typedef struct {
        logic [COUNT_W-1:0] ring;
        logic [COUNT_W-1:0] seg;
        int                 nverts;
        bit                 pole;
    } quad_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_index = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic [COUNT_W-1:0] ring_index = '0;
    logic [COUNT_W-1:0] segment_index = '0;
    logic busy, done, last_vertex;
    logic signed [OUT_W-1:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
    logic [TEX_W-1:0] tex_u, tex_v;
    logic [CORNER_W-1:0] corner;

    logic [COUNT_W-1:0] seg_cnt;
    logic [COUNT_W-1:0] ring_cnt;
    vertex_t            pending_verts[$];
    int                 errors = 0;
    int                 idle_pct = 0;
    int                 quiet_cycles = 0;

    uv_sphere_vertex_generator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .ring_index(ring_index), .segment_index(segment_index),
        .done(done),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .corner(corner), .last_vertex(last_vertex)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint taylor_q30(longint unsigned x, bit want_sin);
        longint unsigned x2, term, dv;
        longint sum;
        x2 = (x * x) >> 30;
        term = want_sin ? x : ONE_Q30;
        sum = longint'(term);
        for (int n = 1; n <= 8; n++)
        begin
            dv = want_sin ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
            term = ((term * x2) >> 30) / dv;
            if (n & 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        return sum;
    endfunction

    function automatic longint sine_rom(longint unsigned k, bit want_sin);
        longint unsigned a, q, m, x, mag;
        longint s0, c0, v;
        a = 4 * (k % DEPTH);
        q = a / DEPTH;
        m = a % DEPTH;
        x = (HALF_PI * m + DEPTH / 2) / DEPTH;
        s0 = taylor_q30(x, 1'b1);
        c0 = taylor_q30(x, 1'b0);
        case (q & 3)
            0: v = want_sin ? s0 : c0;
            1: v = want_sin ? c0 : -s0;
            2: v = want_sin ? -s0 : -c0;
            default: v = want_sin ? -c0 : s0;
        endcase
        mag = (v < 0) ? longint'(-v) : longint'(v);
        mag = (mag + (64'd1 << (30 - FB - 1))) >> (30 - FB);
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [OUT_W-1:0] round_q15(longint v, int from_bits);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        if (from_bits > 15)
            mag = (mag + (64'd1 << (from_bits - 16))) >> (from_bits - 15);
        else
            mag = mag << (15 - from_bits);
        if (v >= 0 && mag > 32767)
            mag = 32767;
        if (v < 0 && mag > 32768)
            mag = 32768;
        return (v < 0) ? OUT_W'(17'h10000 - mag) : OUT_W'(mag);
    endfunction

    // expected vertex words of one quad under the current counts
    task automatic predict_quad(input logic [COUNT_W-1:0] ri,
                                input logic [COUNT_W-1:0] si, output int n);
        longint unsigned rr, ss, r, s, ti, pi;
        longint st, ct, sp, cp, nx, nz;
        vertex_t vx;
        rr = ring_cnt;
        ss = seg_cnt;
        n = 0;
        if (rr == 0 || ss == 0 || ri >= rr || si >= ss)
            return;
        for (int c = 0; c < 6; c++)
        begin
            r = ri + corner_dr(CORNER_W'(c));
            s = si + corner_ds(CORNER_W'(c));
            ti = ((r * DEPTH + rr) / (2 * rr)) % DEPTH;
            pi = ((2 * s * DEPTH + ss) / (2 * ss)) % DEPTH;
            st = sine_rom(ti, 1'b1);
            ct = sine_rom(ti, 1'b0);
            sp = sine_rom(pi, 1'b1);
            cp = sine_rom(pi, 1'b0);
            nx = cp * st;
            nz = sp * st;
            vx.pos_x = round_q15(nx, 2 * FB + 1);
            vx.pos_y = round_q15(ct, FB + 1);
            vx.pos_z = round_q15(nz, 2 * FB + 1);
            vx.norm_x = round_q15(nx, 2 * FB);
            vx.norm_y = round_q15(ct, FB);
            vx.norm_z = round_q15(nz, 2 * FB);
            vx.tex_u = TEX_W'((s * TEX_SCALE2 + ss) / (2 * ss));
            vx.tex_v = TEX_W'((r * TEX_SCALE2 + rr) / (2 * rr));
            vx.corner = CORNER_W'(c);
            vx.last_vertex = (CORNER_W'(c) == LAST_CORNER);
            pending_verts = {pending_verts, vx};
            n++;
        end
    endtask

    task automatic send_quad(input logic [COUNT_W-1:0] ri,
                             input logic [COUNT_W-1:0] si, output int n);
        start <= 1'b1;
        ring_index <= ri;
        segment_index <= si;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_quad(ri, si, n);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic set_counts(input logic [COUNT_W-1:0] sc, input logic [COUNT_W-1:0] rc);
        start <= 1'b0;
        @(posedge clk);
        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SEGMENT_COUNT;
        cfg_data <= sc;
        @(posedge clk);
        cfg_index <= REG_RING_COUNT;
        cfg_data <= rc;
        @(posedge clk);
        cfg_write <= 1'b0;
        seg_cnt = sc;
        ring_cnt = rc;
    endtask

    always @(posedge clk)
    begin
        vertex_t got, want;
        if (rst_n)
        begin
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_MAX)
            begin
                $display("uv_sphere_vertex_generator_top_tb failed");
                $finish;
            end
            if (done)
            begin
                got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                        tex_u, tex_v, corner, last_vertex};
                if (pending_verts.size() == 0)
                begin
                    $display("%0t unexpected word %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_verts.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    quad_row_t quad_rows[] = '{
        '{8'd0,   8'd0,   6, 1'b1},
        '{8'd15,  8'd31,  6, 1'b0},
        '{8'd0,   8'd31,  6, 1'b1},
        '{8'd15,  8'd0,   6, 1'b0},
        '{8'd7,   8'd8,   6, 1'b0},
        '{8'd8,   8'd16,  6, 1'b0},
        '{8'd16,  8'd0,   0, 1'b0},
        '{8'd0,   8'd32,  0, 1'b0},
        '{8'd255, 8'd255, 0, 1'b0},
        '{8'd170, 8'd85,  0, 1'b0},
        '{8'd3,   8'd24,  6, 1'b0}
    };

    logic [COUNT_W-1:0] phase_seg[] = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd2, 8'd100, 8'd77, 8'd32};
    logic [COUNT_W-1:0] phase_ring[] = '{8'd255, 8'd2, 8'd16, 8'd1, 8'd255, 8'd0, 8'd9, 8'd16};

    initial
    begin
        int n, base;
        logic [COUNT_W-1:0] ri, si;
        seg_cnt = SEGMENT_COUNT_RESET;
        ring_cnt = RING_COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 36;
        foreach (quad_rows[i])
        begin
            send_quad(quad_rows[i].ring, quad_rows[i].seg, n);
            // newest quad sits at the back of the queue
            base = pending_verts.size() - n;
            if (n != quad_rows[i].nverts
                || (quad_rows[i].pole && pending_verts[base].norm_y != 16'sd32767))
            begin
                $display("%0t row %0d: expected %0d words actual %0d", $time, i,
                         quad_rows[i].nverts, n);
                errors++;
            end
        end

        for (int p = 0; p < phase_seg.size(); p++)
        begin
            if (p == 3)
                idle_pct = 71;
            if (p == 6)
                idle_pct = 0;
            if (p >= 5 && p <= 6)
                set_counts(COUNT_W'($urandom_range(3, 255)), COUNT_W'($urandom_range(2, 255)));
            else
                set_counts(phase_seg[p], phase_ring[p]);
            for (int k = 0; k < 22; k++)
            begin
                if ($urandom_range(99) < 85 && ring_cnt != 0 && seg_cnt != 0)
                begin
                    ri = $urandom_range(ring_cnt - 1);
                    si = $urandom_range(seg_cnt - 1);
                end
                else
                begin
                    ri = $urandom_range(255);
                    si = $urandom_range(255);
                end
                send_quad(ri, si, n);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("uv_sphere_vertex_generator_top_tb passed");
        else
            $display("uv_sphere_vertex_generator_top_tb failed");
        $finish;
    end

endmodule
